// ===== hw/rtl/islp_pkg.sv =====
package islp_pkg;

  localparam int MAX_LEN = 256;
  localparam int CHAR_W = $clog2(MAX_LEN);
  localparam int LEN_W = 8;
  localparam int INDEX_W = 31;
  localparam int DIGIT_W = 4;
  localparam int PROD_W = INDEX_W + 4;

  localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};
  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = DIGIT_W'(12);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    MODE_INDEX,
    MODE_BETWEEN,
    MODE_STRING,
    MODE_SKIP
  } mode_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [INDEX_W-1:0] index;
    logic [LEN_W-1:0] length;
  } result_t;

endpackage

// ===== hw/rtl/index_string_line_parser.sv =====
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | text_byte, end_of_input
// output   | out_valid / out_ready| result_kind, string_char, line_index, string_length
//
// One byte per cycle is taken when the output side keeps up.
// A byte is held in the input register, and its result is then registered in the output stage.
// The per-byte state update and index multiply-add lie between these two registers.
// Reset is synchronous and returns the parser to the start of a line.
// A stalled output holds only bytes that produce a result; other bytes keep flowing.
module index_string_line_parser
  import islp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         text_byte,
  input  logic               end_of_input,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_kind,
  output logic [7:0]         string_char,
  output logic [INDEX_W-1:0] line_index,
  output logic [LEN_W-1:0]   string_length
);

  logic item_valid;
  logic [7:0] item_byte;
  logic item_eoi;
  logic has_result;
  logic slot_free;
  logic consume;
  result_t result;

  assign consume = item_valid && (!has_result || slot_free);

  islp_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .end_of_input (end_of_input),
    .consume      (consume),
    .item_valid   (item_valid),
    .item_byte    (item_byte),
    .item_eoi     (item_eoi)
  );

  islp_parse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (consume),
    .item_byte  (item_byte),
    .item_eoi   (item_eoi),
    .has_result (has_result),
    .result     (result)
  );

  islp_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (consume && has_result),
    .result        (result),
    .slot_free     (slot_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .string_char   (string_char),
    .line_index    (line_index),
    .string_length (string_length)
  );

endmodule

// ===== hw/rtl/islp_in_stage.sv =====
module islp_in_stage
  import islp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       end_of_input,
  input  logic       consume,
  output logic       item_valid,
  output logic [7:0] item_byte,
  output logic       item_eoi
);

  assign in_ready = !item_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_byte <= text_byte;
      item_eoi <= end_of_input;
    end
  end

endmodule

// ===== hw/rtl/islp_parse_core.sv =====
module islp_parse_core
  import islp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] item_byte,
  input  logic       item_eoi,
  output logic       has_result,
  output result_t    result
);

  mode_t mode, mode_next;
  logic index_seen, index_seen_next;
  logic line_good, line_good_next;
  logic [DIGIT_W-1:0] digit_count, digit_count_next;
  logic [INDEX_W-1:0] index_value, index_value_next;
  logic [CHAR_W-1:0] char_count, char_count_next;

  logic is_blank;
  logic is_digit;
  logic at_limit;
  logic [PROD_W-1:0] index_wide;
  logic [PROD_W-1:0] index_prod;
  logic [INDEX_W-1:0] index_sat;
  logic [DIGIT_W-1:0] digit_inc;

  assign is_blank = (item_byte == CH_SPACE) || (item_byte == CH_TAB);
  assign is_digit = (item_byte >= CH_ZERO) && (item_byte <= CH_NINE);
  assign at_limit = (char_count == CHAR_W'(MAX_LEN - 1));
  assign index_wide = PROD_W'(index_value);
  assign index_prod = (index_wide << 3) + (index_wide << 1) + PROD_W'(item_byte[3:0]);
  assign index_sat = (index_prod > PROD_W'(INDEX_MAX)) ? INDEX_MAX : index_prod[INDEX_W-1:0];
  assign digit_inc = digit_count + DIGIT_W'(1);

  always_comb begin
    mode_next = mode;
    index_seen_next = index_seen;
    line_good_next = line_good;
    digit_count_next = digit_count;
    index_value_next = index_value;
    char_count_next = char_count;
    if (has_result && result.kind != KIND_CHAR) begin
      mode_next = MODE_INDEX;
      index_seen_next = 1'b0;
      line_good_next = 1'b0;
      digit_count_next = '0;
      index_value_next = '0;
      char_count_next = '0;
    end else if (!item_eoi) begin
      unique case (mode)
        MODE_INDEX: begin
          priority if (is_blank) begin
            if (digit_count != '0) begin
              index_seen_next = 1'b1;
            end
          end else if (item_byte == CH_EQUAL) begin
            index_seen_next = 1'b1;
            mode_next = MODE_BETWEEN;
          end else if (is_digit) begin
            if (!index_seen) begin
              index_value_next = index_sat;
              digit_count_next = digit_inc;
              if (digit_inc >= DIGIT_LIMIT) begin
                mode_next = MODE_SKIP;
                line_good_next = 1'b0;
              end
            end
          end else begin
            mode_next = MODE_SKIP;
            line_good_next = 1'b0;
          end
        end
        MODE_BETWEEN: begin
          if (item_byte == CH_HASH) begin
            mode_next = MODE_SKIP;
            line_good_next = 1'b0;
          end else if (item_byte == CH_QUOTE) begin
            mode_next = MODE_STRING;
            char_count_next = '0;
          end
        end
        MODE_STRING: begin
          if (item_byte == CH_QUOTE || at_limit) begin
            mode_next = MODE_SKIP;
            line_good_next = 1'b1;
          end else begin
            char_count_next = char_count + CHAR_W'(1);
          end
        end
        MODE_SKIP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    has_result = 1'b0;
    result.kind = KIND_REJECT;
    result.ch = '0;
    result.index = index_value;
    result.length = LEN_W'(char_count);
    if (item_eoi) begin
      has_result = 1'b1;
      result.kind = (mode == MODE_SKIP && line_good) ? KIND_ACCEPT : KIND_REJECT;
    end else if (item_byte == CH_NEWLINE) begin
      has_result = 1'b1;
      result.kind = (mode == MODE_SKIP && line_good) ? KIND_ACCEPT : KIND_REJECT;
    end else if (mode == MODE_STRING && item_byte != CH_QUOTE && !at_limit) begin
      has_result = 1'b1;
      result.kind = KIND_CHAR;
      result.ch = item_byte;
      result.index = '0;
      result.length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_INDEX;
      index_seen <= 1'b0;
      line_good <= 1'b0;
      digit_count <= '0;
      index_value <= '0;
      char_count <= '0;
    end else if (advance) begin
      mode <= mode_next;
      index_seen <= index_seen_next;
      line_good <= line_good_next;
      digit_count <= digit_count_next;
      index_value <= index_value_next;
      char_count <= char_count_next;
    end
  end

endmodule

// ===== hw/rtl/islp_out_stage.sv =====
module islp_out_stage
  import islp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  result_t             result,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          result_kind,
  output logic [7:0]          string_char,
  output logic [INDEX_W-1:0]  line_index,
  output logic [LEN_W-1:0]    string_length
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind <= result.kind;
      string_char <= result.ch;
      line_index <= result.index;
      string_length <= result.length;
    end
  end

endmodule

// ===== hw/rtl/islp_checker.sv =====
module islp_checker
  import islp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         result_kind,
  input logic [7:0]         string_char,
  input logic [INDEX_W-1:0] line_index,
  input logic [LEN_W-1:0]   string_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(string_char)
      && $stable(line_index) && $stable(string_length))
    else $error("Output transfer changed while stalled.");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_kind != KIND_UNUSED)
    else $error("Illegal result kind.");

  a_char_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_CHAR |-> line_index == '0 && string_length == '0)
    else $error("Character result carries line fields.");

  a_line_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_CHAR |-> string_char == '0
      && string_length <= LEN_W'(MAX_LEN - 1))
    else $error("Line result carries bad character or length.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

endmodule

bind index_string_line_parser islp_checker u_islp_checker (.*);
